@@ src/chained_sector_allocator_top_defines.svh @@
// Assertion macros for the chained sector allocator checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef CHAINED_SECTOR_ALLOCATOR_TOP_DEFINES_SVH
`define CHAINED_SECTOR_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csa check failed");

// next-cycle implication
`define CSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csa check failed");

`endif

@@ src/csa_pkg.sv @@
// Shared constants, types and controller/datapath interface structs.
// No dependencies.
package csa_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int SECT_W      = $clog2(TABLE_DEPTH);
    localparam int SCAN_W      = (SECT_W + 1 > 10) ? SECT_W + 1 : 10;
    localparam int LINK_W      = 16;

    localparam int FDS_W       = 9;
    localparam int LIMIT_W     = 10;
    localparam int SECTOR_W    = 9;
    localparam int COUNT_W     = 9;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_LIMIT = 2'd1;

    localparam logic [LINK_W-1:0]  END_OF_CHAIN = 16'hffff;
    localparam logic [LINK_W-1:0]  NO_SECTOR    = 16'hffff;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;
    localparam logic [FDS_W-1:0]   FDS_RESET    = 9'd14;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd468;
    localparam logic [SCAN_W-1:0]  DEPTH_SCAN   = SCAN_W'(TABLE_DEPTH);
    localparam logic [SECT_W-1:0]  LAST_ENTRY   = SECT_W'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic clr_step;
        logic scan_start;
        logic scan_step;
        logic write_end;
        logic write_link;
        logic load_out;
        logic res_full;
    } csa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic exhausted;
        logic link_needed;
    } csa_status_t;

endpackage

@@ src/csa_ctrl.sv @@
// Sequencer: table clear after reset, first-free scan, table writes, result hand-off.
// Depends on csa_pkg.
module csa_ctrl
    import csa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output csa_cmd_t    cmd,
    input  csa_status_t st
);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_WR_END  = 6'b001000,
        ST_WR_LINK = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   full_reg, full_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign m_tvalid = m_tvalid_reg;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        full_next     = full_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.res_full  = full_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.scan_start = 1'b1;
                    full_next      = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.hit)
                begin
                    state_next = ST_WR_END;
                end
                else if (st.exhausted)
                begin
                    full_next  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_WR_END:
            begin
                cmd.write_end = 1'b1;
                state_next    = st.link_needed ? ST_WR_LINK : ST_EMIT;
            end
            ST_WR_LINK:
            begin
                cmd.write_link = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            full_reg     <= full_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ src/csa_dpath.sv @@
// Link table memory, scan pointer, file state, config registers and result register.
// Depends on csa_pkg.
module csa_dpath
    import csa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  csa_cmd_t              cmd,
    output csa_status_t           st,
    input  logic                  new_file,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [SECTOR_W-1:0]   sector,
    output logic                  disk_full,
    output logic [LINK_W-1:0]     start_sector,
    output logic [COUNT_W-1:0]    file_sectors
);

    logic [LINK_W-1:0]  link_mem [TABLE_DEPTH];
    logic [LINK_W-1:0]  rdata_reg;

    logic [FDS_W-1:0]   first_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [SECT_W-1:0]  clr_addr_reg;
    logic [SCAN_W-1:0]  addr_reg;
    logic               chk_valid_reg;
    logic [SECT_W-1:0]  chk_addr_reg;
    logic [SECT_W-1:0]  found_reg;
    logic [SECT_W-1:0]  link_addr_reg;
    logic               new_file_reg;

    logic [LINK_W-1:0]  prev_reg;
    logic [LINK_W-1:0]  file_start_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_base;

    logic [SECTOR_W-1:0] sector_reg;
    logic                full_out_reg;
    logic [LINK_W-1:0]   start_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic [SCAN_W-1:0]  limit_ext;
    logic [SCAN_W-1:0]  bound;
    logic [SCAN_W-1:0]  found_ext;
    logic               mem_we;
    logic [SECT_W-1:0]  mem_waddr;
    logic [LINK_W-1:0]  mem_wdata;

    assign limit_ext = SCAN_W'(limit_reg);
    assign bound     = (limit_ext > DEPTH_SCAN) ? DEPTH_SCAN : limit_ext;
    assign found_ext = SCAN_W'(found_reg);
    assign count_base = new_file_reg ? '0 : count_reg;

    assign st.clr_last    = (clr_addr_reg == LAST_ENTRY);
    assign st.hit         = chk_valid_reg && (rdata_reg == '0);
    assign st.exhausted   = (addr_reg >= bound);
    assign st.link_needed = !new_file_reg && (prev_reg != NO_SECTOR);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.write_end)
        begin
            mem_we    = 1'b1;
            mem_waddr = found_reg;
            mem_wdata = END_OF_CHAIN;
        end
        else if (cmd.write_link)
        begin
            mem_we    = 1'b1;
            mem_waddr = link_addr_reg;
            mem_wdata = LINK_W'(found_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= link_mem[addr_reg[SECT_W-1:0]];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= FDS_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FIRST_DATA)
            begin
                first_reg <= cfg_data[FDS_W-1:0];
            end
            else if (cfg_index == REG_SECTOR_LIMIT)
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    // clear sweep and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                chk_valid_reg <= !st.exhausted;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            addr_reg     <= SCAN_W'(first_reg);
            new_file_reg <= new_file;
        end
        else if (cmd.scan_step)
        begin
            chk_addr_reg <= addr_reg[SECT_W-1:0];
            if (!st.exhausted)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (st.hit)
            begin
                found_reg <= chk_addr_reg;
            end
        end
        if (cmd.write_end)
        begin
            link_addr_reg <= prev_reg[SECT_W-1:0];
        end
    end

    // file state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= NO_SECTOR;
            file_start_reg <= NO_SECTOR;
            count_reg      <= '0;
        end
        else if (cmd.write_end)
        begin
            prev_reg <= LINK_W'(found_reg);
            if (new_file_reg || (prev_reg == NO_SECTOR))
            begin
                file_start_reg <= LINK_W'(found_reg);
            end
            count_reg <= (count_base < COUNT_MAX) ? count_base + 1'b1 : count_base;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sector_reg    <= cmd.res_full ? '0 : found_ext[SECTOR_W-1:0];
            full_out_reg  <= cmd.res_full;
            start_out_reg <= file_start_reg;
            count_out_reg <= count_reg;
        end
    end

    assign sector       = sector_reg;
    assign disk_full    = full_out_reg;
    assign start_sector = start_out_reg;
    assign file_sectors = count_out_reg;

endmodule

@@ src/chained_sector_allocator_top.sv @@
// Top level of the chained sector allocator: stream ports, config port, ctrl + datapath.
// Depends on csa_pkg, csa_ctrl, csa_dpath.
//
//  channel  | dir | handshake           | payload
//  s_*      | in  | s_tvalid/s_tready   | s_tdata: new_file
//  m_*      | out | m_tvalid/m_tready   | m_tdata: sector, start_sector, file_sectors
//           |     |                     | m_tuser: disk_full
//  cfg_*    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset the link table is cleared one entry per cycle, with s_tready low until all 512 are cleared.
// One request at a time. The scan reads one table entry per cycle from the single
// memory read port, then one or two table writes (the end-of-chain mark, then the link
// from the previous sector when needed) and a load of the output register follow.
// A waiting result holds the sequencer in its output state until m_tready.
module chained_sector_allocator_top
    import csa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [0] new_file, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [8:0] sector, [24:9] start_sector,
                                              // [33:25] file_sectors, [39:34] zero
    output logic                  m_tuser,    // [0] disk_full
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    csa_cmd_t            cmd;
    csa_status_t         st;
    logic [SECTOR_W-1:0] sector;
    logic [LINK_W-1:0]   start_sector;
    logic [COUNT_W-1:0]  file_sectors;

    assign cfg_ready = 1'b1;

    csa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    csa_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .new_file     (s_tdata[0]),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sector       (sector),
        .disk_full    (m_tuser),
        .start_sector (start_sector),
        .file_sectors (file_sectors)
    );

    assign m_tdata = M_TDATA_W'({file_sectors, start_sector, sector});

endmodule

@@ src/csa_checker.sv @@
// Port-level checker for the chained sector allocator, bound to the top level.
// Depends on csa_pkg and chained_sector_allocator_top_defines.svh.
`include "chained_sector_allocator_top_defines.svh"

module csa_checker
    import csa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    `CSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CSA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `CSA_ASSERT_NOW(a_full_sector_zero, m_tvalid && m_tuser, m_tdata[8:0] == '0)
    `CSA_ASSERT_NOW(a_alloc_counted, m_tvalid && !m_tuser, m_tdata[33:25] != '0)

endmodule

bind chained_sector_allocator_top csa_checker u_csa_checker (.*);

@@ bench/tb_top.sv @@
// Testbench for chained_sector_allocator_top: directed and random allocation requests
// under random window settings, each result checked against a sector-chain predictor.
// Depends on csa_pkg and the RTL of chained_sector_allocator_top.
module tb_top;
    import csa_pkg::*;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                disk_full;
        logic [LINK_W-1:0]   start_sector;
        logic [COUNT_W-1:0]  file_sectors;
    } alloc_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [LINK_W-1:0]  chain_map [TABLE_DEPTH];
    logic [LINK_W-1:0]  last_sector;
    logic [LINK_W-1:0]  file_head;
    logic [COUNT_W-1:0] file_len;
    logic [FDS_W-1:0]   data_base;
    logic [LIMIT_W-1:0] disk_size;

    alloc_result_t pending_allocs [$];
    alloc_result_t want;
    int            errors = 0;
    int            sent   = 0;
    bit            steady = 1'b0;

    always #2 clk = ~clk;

    chained_sector_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int first_free();
        int bound;
        bound = (int'(disk_size) > TABLE_DEPTH) ? TABLE_DEPTH : int'(disk_size);
        for (int s = int'(data_base); s < bound; s++)
        begin
            if (chain_map[s] == '0)
                return s;
        end
        return -1;
    endfunction

    function automatic alloc_result_t allocate_sector(input logic begin_file);
        alloc_result_t r;
        int            s;
        s = first_free();
        if (s < 0)
        begin
            r.sector       = '0;
            r.disk_full    = 1'b1;
            r.start_sector = file_head;
            r.file_sectors = file_len;
            return r;
        end
        chain_map[s] = END_OF_CHAIN;
        if (begin_file)
        begin
            last_sector = NO_SECTOR;
            file_len    = '0;
        end
        if (last_sector == NO_SECTOR)
            file_head = LINK_W'(s);
        else if (last_sector < TABLE_DEPTH)
            chain_map[last_sector] = LINK_W'(s);
        if (file_len < COUNT_MAX)
            file_len = file_len + 1'b1;
        last_sector    = LINK_W'(s);
        r.sector       = SECTOR_W'(s);
        r.disk_full    = 1'b0;
        r.start_sector = file_head;
        r.file_sectors = file_len;
        return r;
    endfunction

    task automatic push_request(input logic begin_file);
        if (!steady && $urandom_range(0, 99) < 35)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 35);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(begin_file);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_allocs.push_back(allocate_sector(begin_file));
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
    endtask

    // both registers, one beat each, valid held high between them
    task automatic set_window(input int unsigned base, input int unsigned size);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FIRST_DATA;
        cfg_data  <= CFG_DATA_W'(base);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        data_base = FDS_W'(base);
        cfg_index <= REG_SECTOR_LIMIT;
        cfg_data  <= CFG_DATA_W'(size);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        disk_size = LIMIT_W'(size);
        cfg_valid <= 1'b0;
    endtask

    // empty search range: base equal to limit, base above limit; no file yet
    task automatic test_empty_window();
        set_window(300, 300);
        push_request(1'b1);
        push_request(1'b0);
        drain();
        set_window(400, 100);
        push_request(1'b0);
        drain();
    endtask

    // continue with no file open, then a real new file
    task automatic test_first_request();
        set_window(int'(FDS_RESET), int'(LIMIT_RESET));
        push_request(1'b0);
        push_request(1'b1);
        push_request(1'b0);
        drain();
    endtask

    // window fills up; new-file request on a full disk must not start a file
    task automatic test_full_window();
        set_window(20, 22);
        push_request(1'b0);
        push_request(1'b0);
        push_request(1'b1);
        push_request(1'b0);
        drain();
    endtask

    // top and bottom sectors; linking to sector 0 frees the previous tail
    task automatic test_edge_sectors();
        set_window(TABLE_DEPTH - 1, TABLE_DEPTH);
        push_request(1'b0);
        push_request(1'b1);
        drain();
        set_window(0, 1);
        push_request(1'b0);
        drain();
        set_window(TABLE_DEPTH - 1, TABLE_DEPTH);
        push_request(1'b0);
        drain();
    endtask

    // new-file beats only when the window is full, so one chain can reach the count ceiling
    task automatic test_random_windows();
        int unsigned base;
        int unsigned size;
        int unsigned n;
        while (sent < 700)
        begin
            steady = (sent >= 250 && sent < 400);
            case ($urandom_range(0, 9))
                0:
                begin
                    base = 0;
                    size = TABLE_DEPTH;
                end
                1:
                begin
                    base = TABLE_DEPTH - 1;
                    size = TABLE_DEPTH;
                end
                2:
                begin
                    base = $urandom_range(256, TABLE_DEPTH - 1);
                    size = $urandom_range(1, base);
                end
                default:
                begin
                    base = $urandom_range(0, TABLE_DEPTH - 1);
                    size = base + $urandom_range(1, 48);
                    if (size > TABLE_DEPTH)
                        size = TABLE_DEPTH;
                end
            endcase
            set_window(base, size);
            n = $urandom_range(4, 30);
            repeat (n)
            begin
                if (first_free() < 0)
                    push_request(1'($urandom_range(0, 1)));
                else
                    push_request(1'b0);
            end
            drain();
        end
        steady = 1'b0;
    endtask

    // fill every remaining free sector into the current chain, then keep hitting disk full
    task automatic test_count_ceiling();
        set_window(0, TABLE_DEPTH);
        while (first_free() >= 0)
            push_request(1'b0);
        repeat (10)
            push_request(1'($urandom_range(0, 1)));
        while (sent < 950)
            push_request(1'($urandom_range(0, 1)));
        drain();
    endtask

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 35);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_allocs.size() == 0)
            begin
                $error("result beat with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_allocs.pop_front();
                if (m_tdata[0 +: SECTOR_W] !== want.sector)
                begin
                    $error("sector: expected %0d, got %0d", want.sector,
                           m_tdata[0 +: SECTOR_W]);
                    errors++;
                end
                if (m_tuser !== want.disk_full)
                begin
                    $error("disk_full: expected %0d, got %0d", want.disk_full, m_tuser);
                    errors++;
                end
                if (m_tdata[SECTOR_W +: LINK_W] !== want.start_sector)
                begin
                    $error("start_sector: expected %0d, got %0d", want.start_sector,
                           m_tdata[SECTOR_W +: LINK_W]);
                    errors++;
                end
                if (m_tdata[SECTOR_W + LINK_W +: COUNT_W] !== want.file_sectors)
                begin
                    $error("file_sectors: expected %0d, got %0d", want.file_sectors,
                           m_tdata[SECTOR_W + LINK_W +: COUNT_W]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        foreach (chain_map[i])
            chain_map[i] = '0;
        last_sector = NO_SECTOR;
        file_head   = NO_SECTOR;
        file_len    = '0;
        data_base   = FDS_RESET;
        disk_size   = LIMIT_RESET;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        test_empty_window();
        test_first_request();
        test_full_window();
        test_edge_sectors();
        test_random_windows();
        test_count_ceiling();
        repeat (600)
            @(posedge clk);
        if (errors == 0)
            $display("[chained_sector_allocator_top] OK");
        else
            $display("[chained_sector_allocator_top] ERROR");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("[chained_sector_allocator_top] ERROR");
        $finish;
    end

endmodule

@@ chained_sector_allocator_top.f @@
+incdir+src
src/csa_pkg.sv
src/csa_ctrl.sv
src/csa_dpath.sv
src/chained_sector_allocator_top.sv
src/csa_checker.sv
bench/tb_top.sv
